/* rtl/pba_pkg.sv */
// shared constants, request codes and structs for the page bitmap allocator
package pba_pkg;

  localparam int TOTAL_ENTRIES    = 4096;
  localparam int TABLE_ENTRIES    = 256;
  localparam int FRAME_START_BYTE = 32;

  localparam int IDX_W  = 12;
  localparam int ADDR_W = 32;
  localparam int PAGE_SHIFT = 12;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ROWS      = (TOTAL_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int ENTRY_W   = $clog2(ROWS * WORD_BITS);
  localparam int ROW_W     = ENTRY_W - BIT_W;
  localparam int CNT_W     = ENTRY_W + 1;

  localparam int TABLE_LIMIT =
    (TABLE_ENTRIES > TOTAL_ENTRIES) ? TOTAL_ENTRIES : TABLE_ENTRIES;
  localparam int FRAME_START = FRAME_START_BYTE * 8;
  localparam bit FRAME_EMPTY = (FRAME_START >= TOTAL_ENTRIES);

  localparam logic [ROW_W-1:0] TABLE_LAST_ROW = ROW_W'((TABLE_LIMIT - 1) / WORD_BITS);
  localparam logic [ROW_W-1:0] FRAME_FIRST_ROW =
    FRAME_EMPTY ? '0 : ROW_W'(FRAME_START / WORD_BITS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  // request codes
  localparam logic [1:0] REQ_TBL1  = 2'd0;
  localparam logic [1:0] REQ_TBL4  = 2'd1;
  localparam logic [1:0] REQ_FRAME = 2'd2;
  localparam logic [1:0] REQ_FREE  = 2'd3;

  // scan unit operations
  localparam logic [1:0] OP_SET1 = 2'd0;
  localparam logic [1:0] OP_SET4 = 2'd1;
  localparam logic [1:0] OP_CLR  = 2'd2;

  // configuration register byte offsets
  localparam logic [2:0] ADDR_REGION_BASE = 3'd0;

  typedef struct packed {
    logic [1:0]       op;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
  } scan_cmd_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_W-1:0]     pos;
    logic [WORD_BITS-1:0] word;
  } scan_res_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ROW_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } map_req_t;

endpackage

/* rtl/pba_scan.sv */
// shared row scan unit: finds a free entry or aligned group, or clears an entry, and builds the updated row
module pba_scan (
  input  pba_pkg::scan_cmd_t                cmd,
  input  logic [pba_pkg::ROW_W-1:0]         row,
  input  logic [pba_pkg::WORD_BITS-1:0]     word,
  output pba_pkg::scan_res_t                res
);

  localparam int NIBS = pba_pkg::WORD_BITS / 4;

  logic [pba_pkg::WORD_BITS-1:0] in_rng;
  logic [pba_pkg::WORD_BITS-1:0] free1;
  logic [NIBS-1:0]               free4;
  logic                          found1;
  logic                          found4;
  logic [pba_pkg::BIT_W-1:0]     pos1;
  logic [pba_pkg::BIT_W-1:0]     pos4;
  logic [pba_pkg::BIT_W-1:0]     pos_clr;

  // entry number of each bit against the region bounds
  always_comb begin
    logic [pba_pkg::CNT_W-1:0] e;
    e = '0;
    for (int b = 0; b < pba_pkg::WORD_BITS; b++) begin
      e = {1'b0, row, pba_pkg::BIT_W'(b)};
      in_rng[b] = (e >= cmd.lo) && (e < cmd.hi);
    end
  end

  assign free1 = ~word & in_rng;

  always_comb begin
    for (int k = 0; k < NIBS; k++) begin
      free4[k] = (word[4*k +: 4] == 4'h0) && in_rng[4*k] && in_rng[4*k+3];
    end
  end

  // first set bit, lowest wins
  always_comb begin
    found1 = 1'b0;
    pos1   = '0;
    for (int b = pba_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (free1[b]) begin
        found1 = 1'b1;
        pos1   = pba_pkg::BIT_W'(b);
      end
    end
  end

  always_comb begin
    found4 = 1'b0;
    pos4   = '0;
    for (int k = NIBS - 1; k >= 0; k--) begin
      if (free4[k]) begin
        found4 = 1'b1;
        pos4   = pba_pkg::BIT_W'(4 * k);
      end
    end
  end

  assign pos_clr = cmd.lo[pba_pkg::BIT_W-1:0];

  always_comb begin
    res = '0;
    case (cmd.op)
      pba_pkg::OP_SET1: begin
        res.found = found1;
        res.pos   = pos1;
        res.word  = word | (pba_pkg::WORD_BITS'(1) << pos1);
      end
      pba_pkg::OP_SET4: begin
        res.found = found4;
        res.pos   = pos4;
        res.word  = word | (pba_pkg::WORD_BITS'(4'hF) << pos4);
      end
      pba_pkg::OP_CLR: begin
        res.found = 1'b1;
        res.pos   = pos_clr;
        res.word  = word & ~(pba_pkg::WORD_BITS'(1) << pos_clr);
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

/* rtl/pba_map.sv */
// used/free bitmap memory, one 64-entry row per word, with per-row valid bits
module pba_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pba_pkg::map_req_t             req,
  output logic [pba_pkg::WORD_BITS-1:0] rdata
);

  logic [pba_pkg::WORD_BITS-1:0] mem [pba_pkg::ROWS];
  logic [pba_pkg::ROWS-1:0]      vld_r;
  logic [pba_pkg::WORD_BITS-1:0] rdata_r;
  logic                          rvld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  // a row never written since reset reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

/* rtl/page_bitmap_allocator_core.sv */
// page bitmap allocator top level: request sequencer, config register and result stage
// allocations scan one 64-entry bitmap row per cycle through the shared scan unit:
// on a hit the item passes the prime, scan and write states before the result,
// and a dry scan goes straight to the result; rows scanned: table 1..4, frame 1..60
// a free takes one read-modify-write of its row via the prime, scan and write states
// failures known at accept give a result the next cycle; one item in flight at a time,
// the next item is taken the cycle after the result is taken
// reset clears the row valid bits at once, so the whole map reads free with no clear pass
module page_bitmap_allocator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [pba_pkg::IDX_W-1:0]   in_free_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic [pba_pkg::IDX_W-1:0]   out_entry_index,
  output logic [pba_pkg::ADDR_W-1:0]  out_page_address,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [2:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRIME = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WR    = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [pba_pkg::ROW_W-1:0]       rd_row_r, rd_row_nxt;
  logic [pba_pkg::ROW_W-1:0]       last_row_r, last_row_nxt;
  pba_pkg::scan_cmd_t              cmd_r, cmd_nxt;
  logic [pba_pkg::ENTRY_W-1:0]     idx_r, idx_nxt;
  logic [pba_pkg::WORD_BITS-1:0]   wdata_r, wdata_nxt;
  logic [31:0]                     region_base_r;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_ok_r, out_ok_nxt;
  logic [pba_pkg::IDX_W-1:0]       out_entry_index_r, out_entry_index_nxt;
  logic [pba_pkg::ADDR_W-1:0]      out_page_address_r, out_page_address_nxt;

  pba_pkg::map_req_t               map_req;
  logic [pba_pkg::WORD_BITS-1:0]   map_rdata;
  pba_pkg::scan_res_t              scan_res;

  logic                            in_acc;
  logic                            free_oor;
  logic [pba_pkg::ENTRY_W-1:0]     free_entry;
  logic                            cfg_wr;

  pba_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (map_req),
    .rdata (map_rdata)
  );

  pba_scan u_scan (
    .cmd  (cmd_r),
    .row  (rd_row_r),
    .word (map_rdata),
    .res  (scan_res)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == pba_pkg::ADDR_REGION_BASE[2]);
  assign cfg_prdata = (cfg_paddr[2] == pba_pkg::ADDR_REGION_BASE[2]) ? region_base_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
    end else if (cfg_wr) begin
      region_base_r <= cfg_pwdata;
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign free_oor   = (32'(in_free_index) >= 32'(pba_pkg::TOTAL_ENTRIES));
  assign free_entry = pba_pkg::ENTRY_W'(in_free_index);

  // bitmap port: reads stream one row per cycle while scanning
  always_comb begin
    map_req         = '0;
    map_req.rd_addr = rd_row_r;
    map_req.wr_addr = idx_r[pba_pkg::ENTRY_W-1:pba_pkg::BIT_W];
    map_req.wr_data = wdata_r;
    if (state_r == ST_PRIME) begin
      map_req.rd_en = 1'b1;
    end else if (state_r == ST_SCAN && !scan_res.found && rd_row_r != last_row_r) begin
      map_req.rd_en   = 1'b1;
      map_req.rd_addr = rd_row_r + 1'b1;
    end
    map_req.wr_en = (state_r == ST_WR);
  end

  always_comb begin
    state_nxt            = state_r;
    rd_row_nxt           = rd_row_r;
    last_row_nxt         = last_row_r;
    cmd_nxt              = cmd_r;
    idx_nxt              = idx_r;
    wdata_nxt            = wdata_r;
    out_valid_nxt        = out_valid_r;
    out_ok_nxt           = out_ok_r;
    out_entry_index_nxt  = out_entry_index_r;
    out_page_address_nxt = out_page_address_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_PRIME;
          case (in_req_type)
            pba_pkg::REQ_TBL1: begin
              cmd_nxt.op   = pba_pkg::OP_SET1;
              cmd_nxt.lo   = '0;
              cmd_nxt.hi   = pba_pkg::CNT_W'(pba_pkg::TABLE_LIMIT);
              rd_row_nxt   = '0;
              last_row_nxt = pba_pkg::TABLE_LAST_ROW;
            end
            pba_pkg::REQ_TBL4: begin
              cmd_nxt.op   = pba_pkg::OP_SET4;
              cmd_nxt.lo   = '0;
              cmd_nxt.hi   = pba_pkg::CNT_W'(pba_pkg::TABLE_LIMIT);
              rd_row_nxt   = '0;
              last_row_nxt = pba_pkg::TABLE_LAST_ROW;
            end
            pba_pkg::REQ_FRAME: begin
              cmd_nxt.op   = pba_pkg::OP_SET1;
              cmd_nxt.lo   = pba_pkg::CNT_W'(pba_pkg::FRAME_START);
              cmd_nxt.hi   = pba_pkg::CNT_W'(pba_pkg::TOTAL_ENTRIES);
              rd_row_nxt   = pba_pkg::FRAME_FIRST_ROW;
              last_row_nxt = pba_pkg::LAST_ROW;
            end
            default: begin
              cmd_nxt.op   = pba_pkg::OP_CLR;
              cmd_nxt.lo   = {1'b0, free_entry};
              cmd_nxt.hi   = pba_pkg::CNT_W'(pba_pkg::TOTAL_ENTRIES);
              rd_row_nxt   = free_entry[pba_pkg::ENTRY_W-1:pba_pkg::BIT_W];
              last_row_nxt = free_entry[pba_pkg::ENTRY_W-1:pba_pkg::BIT_W];
            end
          endcase
          // requests that fail without touching the map
          if ((in_req_type == pba_pkg::REQ_FREE && free_oor) ||
              (in_req_type == pba_pkg::REQ_FRAME && pba_pkg::FRAME_EMPTY)) begin
            state_nxt            = ST_RESP;
            out_valid_nxt        = 1'b1;
            out_ok_nxt           = 1'b0;
            out_entry_index_nxt  = '0;
            out_page_address_nxt = '0;
          end
        end
      end
      ST_PRIME: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_res.found) begin
          state_nxt = ST_WR;
          idx_nxt   = {rd_row_r, scan_res.pos};
          wdata_nxt = scan_res.word;
        end else if (rd_row_r == last_row_r) begin
          state_nxt            = ST_RESP;
          out_valid_nxt        = 1'b1;
          out_ok_nxt           = 1'b0;
          out_entry_index_nxt  = '0;
          out_page_address_nxt = '0;
        end else begin
          rd_row_nxt = rd_row_r + 1'b1;
        end
      end
      ST_WR: begin
        state_nxt            = ST_RESP;
        out_valid_nxt        = 1'b1;
        out_ok_nxt           = 1'b1;
        out_entry_index_nxt  = pba_pkg::IDX_W'(idx_r);
        out_page_address_nxt = region_base_r +
                               (pba_pkg::ADDR_W'(idx_r) << pba_pkg::PAGE_SHIFT);
      end
      ST_RESP: begin
        if (!out_stall) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_row_r           <= rd_row_nxt;
    last_row_r         <= last_row_nxt;
    cmd_r              <= cmd_nxt;
    idx_r              <= idx_nxt;
    wdata_r            <= wdata_nxt;
    out_ok_r           <= out_ok_nxt;
    out_entry_index_r  <= out_entry_index_nxt;
    out_page_address_r <= out_page_address_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_entry_index  = out_entry_index_r;
  assign out_page_address = out_page_address_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken while an item is in flight");

  a_result_only_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_RESP))
    else $error("result shown outside the response state");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_entry_index_r == '0 && out_page_address_r == '0))
    else $error("failed item carries a nonzero index or address");

  a_scan_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_row_r <= last_row_r))
    else $error("row scan ran past its last row");

  a_write_after_find: assert property (@(posedge clk) disable iff (!rst_n)
    map_req.wr_en |-> $past(state_r == ST_SCAN && scan_res.found))
    else $error("bitmap written without a found entry");

endmodule
